// File: rtl/c2uph_pkg.sv
// Package for the complex-to-unwrapped-phase block: widths, arctangent table, shared types.
package c2uph_pkg;

    localparam int SAMPLE_BITS   = 24;
    localparam int ANGLE_BITS    = 16;
    localparam int PHASE_BITS    = 32;
    localparam int CORDIC_STAGES = 16;

    // rotator width: sign, negation of the most negative sample, CORDIC gain
    localparam int XY_BITS    = SAMPLE_BITS + 3;
    localparam int Z_BITS     = 32;
    localparam int STAGE_BITS = $clog2(CORDIC_STAGES);
    localparam int TABLE_LEN  = 24;
    localparam int TBL_BITS   = $clog2(TABLE_LEN);

    // atan(2^-i) in units of 2^-32 circle
    localparam logic [Z_BITS-1:0] ATAN_TABLE [TABLE_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85135828,
        32'd42733891,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    localparam logic [Z_BITS-1:0] Z_HALF_CIRCLE = Z_BITS'(1) << (Z_BITS - 1);
    localparam logic [Z_BITS-1:0] Z_ROUND_HALF  = Z_BITS'(1) << (Z_BITS - 1 - ANGLE_BITS);

    localparam logic signed [PHASE_BITS-1:0] PHASE_MAX = {1'b0, {(PHASE_BITS-1){1'b1}}};
    localparam logic signed [PHASE_BITS-1:0] PHASE_MIN = {1'b1, {(PHASE_BITS-1){1'b0}}};

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROTATE,
        S_UNWRAP
    } t_state;

    typedef struct packed {
        logic                         done;
        logic signed [ANGLE_BITS-1:0] angle;
    } t_cordic_res;

endpackage

// File: rtl/complex_to_unwrapped_phase.sv
// Top level: CORDIC atan2 of a complex sample followed by saturating phase unwrap.
//
// One sample at a time: a beat is taken only while o_in_stall is low, then
// the shared CORDIC rotator runs one micro-rotation per cycle for CORDIC_STAGES
// micro-rotations, the sequencer sees the rotator finish, and the unwrap step computes
// the phase and loads the output register, waiting there while the output register stays
// full under i_out_stall. The next sample is taken only after that load. The
// wrapped angle is a 16-bit binary angle
// (32768 = pi); the unwrapped phase follows the previous output by the nearest
// full-circle multiple, a step of exactly pi counting as -pi, and clamps at the
// 32-bit signed limits with o_saturated set. A beat with i_record_start restarts
// unwrapping from the wrapped angle. Reset sets the previous phase to zero.
module complex_to_unwrapped_phase import c2uph_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_real_part,
    input  logic signed [SAMPLE_BITS-1:0] i_imag_part,
    input  logic                          i_record_start,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [PHASE_BITS-1:0]  o_unwrapped_phase,
    output logic signed [ANGLE_BITS-1:0]  o_wrapped_angle,
    output logic                          o_saturated
);

    t_state r_state, n_state;

    logic                         r_start;
    logic signed [PHASE_BITS-1:0] r_prev, n_prev;
    logic                         r_out_valid, n_out_valid;
    logic signed [PHASE_BITS-1:0] r_phase_out;
    logic signed [ANGLE_BITS-1:0] r_angle_out;
    logic                         r_sat;

    t_cordic_res cordic_res;

    logic                         in_beat;
    logic                         out_free;
    logic                         out_load;
    logic signed [ANGLE_BITS-1:0] delta;
    logic signed [PHASE_BITS:0]   sum;
    logic signed [PHASE_BITS-1:0] phase_next;
    logic                         sat_next;

    assign in_beat  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    c2uph_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (in_beat),
        .i_re    (i_real_part),
        .i_im    (i_imag_part),
        .o_res   (cordic_res)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_ROTATE;
            end
            S_ROTATE: begin
                if (cordic_res.done) n_state = S_UNWRAP;
            end
            S_UNWRAP: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall = 1'b1;
        out_load   = 1'b0;
        case (r_state)
            S_IDLE:   o_in_stall = 1'b0;
            S_ROTATE: o_in_stall = 1'b1;
            S_UNWRAP: out_load   = out_free;
            default:  o_in_stall = 1'b1;
        endcase
    end

    // step wrapped to one circle, then added at full width with overflow clamp
    assign delta = cordic_res.angle - r_prev[ANGLE_BITS-1:0];
    assign sum   = (PHASE_BITS+1)'(r_prev) + (PHASE_BITS+1)'(delta);

    always_comb begin
        if (r_start) begin
            phase_next = PHASE_BITS'(cordic_res.angle);
            sat_next   = 1'b0;
        end else if (sum[PHASE_BITS] != sum[PHASE_BITS-1]) begin
            phase_next = sum[PHASE_BITS] ? PHASE_MIN : PHASE_MAX;
            sat_next   = 1'b1;
        end else begin
            phase_next = sum[PHASE_BITS-1:0];
            sat_next   = 1'b0;
        end
    end

    always_comb begin
        n_prev      = r_prev;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) n_out_valid = 1'b0;
        if (out_load) begin
            n_prev      = phase_next;
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_prev      <= n_prev;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) r_start <= i_record_start;
        if (out_load) begin
            r_phase_out <= phase_next;
            r_angle_out <= cordic_res.angle;
            r_sat       <= sat_next;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_unwrapped_phase = r_phase_out;
    assign o_wrapped_angle   = r_angle_out;
    assign o_saturated       = r_sat;

    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> (o_in_stall && !cordic_res.done))
        else $error("rotator not busy after input beat");

    a_out_from_unwrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_UNWRAP))
        else $error("output beat raised outside unwrap step");

    a_start_no_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_start) |=> (!o_saturated &&
            o_unwrapped_phase == PHASE_BITS'(o_wrapped_angle)))
        else $error("record start result not the wrapped angle");

    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |->
            (o_unwrapped_phase == PHASE_MAX || o_unwrapped_phase == PHASE_MIN))
        else $error("saturated flag without clamped phase");

    a_prev_tracks_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_prev == o_unwrapped_phase))
        else $error("previous phase differs from delivered phase");

endmodule

// File: rtl/c2uph_cordic.sv
// Iterative vectoring CORDIC: one micro-rotation per cycle, binary angle out.
module c2uph_cordic import c2uph_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic signed [SAMPLE_BITS-1:0] i_re,
    input  logic signed [SAMPLE_BITS-1:0] i_im,
    output t_cordic_res                   o_res
);

    logic                      r_busy, n_busy;
    logic [STAGE_BITS-1:0]     r_count, n_count;
    logic signed [XY_BITS-1:0] r_x, n_x;
    logic signed [XY_BITS-1:0] r_y, n_y;
    logic [Z_BITS-1:0]         r_z, n_z;
    logic                      r_zero, n_zero;

    logic signed [XY_BITS-1:0] re_ext, im_ext;
    logic signed [XY_BITS-1:0] xs, ys;
    logic [Z_BITS-1:0]         atan_val;
    logic [Z_BITS-1:0]         z_round;
    logic                      cw;

    assign re_ext   = XY_BITS'(i_re);
    assign im_ext   = XY_BITS'(i_im);
    assign xs       = r_x >>> r_count;
    assign ys       = r_y >>> r_count;
    assign atan_val = ATAN_TABLE[TBL_BITS'(r_count)];
    assign cw       = ~r_y[XY_BITS-1];

    always_comb begin
        n_busy  = r_busy;
        n_count = r_count;
        n_x     = r_x;
        n_y     = r_y;
        n_z     = r_z;
        n_zero  = r_zero;
        if (i_load) begin
            // fold the left half plane over so the rotator starts within +-pi/2
            n_busy  = 1'b1;
            n_count = '0;
            n_zero  = (i_re == '0) && (i_im == '0);
            if (re_ext[XY_BITS-1]) begin
                n_x = -re_ext;
                n_y = -im_ext;
                n_z = Z_HALF_CIRCLE;
            end else begin
                n_x = re_ext;
                n_y = im_ext;
                n_z = '0;
            end
        end else if (r_busy) begin
            if (cw) begin
                n_x = r_x + ys;
                n_y = r_y - xs;
                n_z = r_z + atan_val;
            end else begin
                n_x = r_x - ys;
                n_y = r_y + xs;
                n_z = r_z - atan_val;
            end
            if (r_count == STAGE_BITS'(CORDIC_STAGES - 1)) begin
                n_busy = 1'b0;
            end else begin
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_count <= n_count;
        r_x     <= n_x;
        r_y     <= n_y;
        r_z     <= n_z;
        r_zero  <= n_zero;
    end

    // round to the output angle width; +pi wraps to -pi on its own
    assign z_round     = r_z + Z_ROUND_HALF;
    assign o_res.done  = ~r_busy;
    assign o_res.angle = r_zero ? '0 : $signed(z_round[Z_BITS-1 -: ANGLE_BITS]);

endmodule

// File: verif/complex_to_unwrapped_phase_checker.sv
// Scoreboard for complex_to_unwrapped_phase: predicts CORDIC angle and unwrapped phase per beat.
module complex_to_unwrapped_phase_checker import c2uph_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_real_part,
    input  logic signed [SAMPLE_BITS-1:0] i_imag_part,
    input  logic                          i_record_start,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic signed [PHASE_BITS-1:0]  i_unwrapped_phase,
    input  logic signed [ANGLE_BITS-1:0]  i_wrapped_angle,
    input  logic                          i_saturated,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_checked,
    output int                            o_starts,
    output int                            o_saturations
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [PHASE_BITS-1:0] phase;
        logic signed [ANGLE_BITS-1:0] angle;
        logic                         sat;
    } t_phase_beat;

    t_phase_beat phase_q[$];
    longint      last_phase;
    int          fails;
    int          checked;
    int          starts;
    int          saturations;

    // vectoring CORDIC, angle kept as a 32-bit binary angle until the final rounding
    function automatic logic signed [ANGLE_BITS-1:0] cordic_angle(input longint x,
                                                                 input longint y);
        logic [Z_BITS-1:0] z;
        logic [Z_BITS-1:0] rounded;
        longint            xs;
        longint            ys;
        int                n_stages;
        if (x == 0 && y == 0)
            return '0;
        z = '0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = Z_HALF_CIRCLE;
        end
        n_stages = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
        for (int i = 0; i < n_stages; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_TABLE[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_TABLE[i];
            end
        end
        rounded = z + Z_ROUND_HALF;
        return $signed(rounded[Z_BITS-1 -: ANGLE_BITS]);
    endfunction

    function automatic t_phase_beat predict_beat(input logic signed [SAMPLE_BITS-1:0] re,
                                                 input logic signed [SAMPLE_BITS-1:0] im,
                                                 input logic start);
        t_phase_beat            beat;
        logic [ANGLE_BITS-1:0]  diff;
        longint                 next_phase;
        beat.angle = cordic_angle(longint'(re), longint'(im));
        beat.sat   = 1'b0;
        if (start) begin
            next_phase = longint'($signed(beat.angle));
        end else begin
            // nearest full-circle correction; a step of exactly pi lands on -pi
            diff       = beat.angle - last_phase[ANGLE_BITS-1:0];
            next_phase = last_phase + longint'($signed(diff));
            if (next_phase > longint'(PHASE_MAX)) begin
                next_phase = longint'(PHASE_MAX);
                beat.sat   = 1'b1;
            end else if (next_phase < longint'(PHASE_MIN)) begin
                next_phase = longint'(PHASE_MIN);
                beat.sat   = 1'b1;
            end
        end
        last_phase = next_phase;
        beat.phase = next_phase[PHASE_BITS-1:0];
        return beat;
    endfunction

    always @(posedge i_clk) begin
        t_phase_beat want;
        if (!i_rst_n) begin
            phase_q.delete();
            last_phase  = 0;
            fails       = 0;
            checked     = 0;
            starts      = 0;
            saturations = 0;
        end else begin
            // check the output side first so a stray beat never meets its own prediction
            if (i_out_valid && !i_out_stall) begin
                if (phase_q.size() == 0) begin
                    $display("%0t: unexpected beat: phase %0d angle %0d sat %0b", $time,
                             i_unwrapped_phase, i_wrapped_angle, i_saturated);
                    fails++;
                end else begin
                    want = phase_q.pop_front();
                    checked++;
                    if (want.sat)
                        saturations++;
                    if (i_unwrapped_phase !== want.phase) begin
                        $display("%0t: unwrapped_phase expected %0d got %0d", $time,
                                 want.phase, i_unwrapped_phase);
                        fails++;
                    end
                    if (i_wrapped_angle !== want.angle) begin
                        $display("%0t: wrapped_angle expected %0d got %0d", $time,
                                 want.angle, i_wrapped_angle);
                        fails++;
                    end
                    if (i_saturated !== want.sat) begin
                        $display("%0t: saturated expected %0b got %0b", $time,
                                 want.sat, i_saturated);
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_record_start)
                    starts++;
                phase_q.push_back(predict_beat(i_real_part, i_imag_part, i_record_start));
            end
        end
        o_fail_count  <= fails;
        o_pending     <= phase_q.size();
        o_checked     <= checked;
        o_starts      <= starts;
        o_saturations <= saturations;
    end

endmodule

// File: verif/complex_to_unwrapped_phase_tb.sv
// Testbench top for complex_to_unwrapped_phase: stimulus, flow control, watchdog and verdict.
module complex_to_unwrapped_phase_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import c2uph_pkg::*;

    localparam int  QUIET_LIMIT = 4000;
    localparam int  RAMP_ITEMS  = 40;
    localparam int  PHASE_ITEMS = 150;
    localparam int  TAIL_CYCLES = 4 * (CORDIC_STAGES + 2);
    localparam real PI          = 3.14159265358979;
    // a bit under half a circle per beat: fastest monotonic walk
    localparam real RAMP_STEP   = 2.0 * PI * 16.0 / 33.0;

    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic                          i_clk          = 1'b0;
    logic                          i_rst_n        = 1'b0;
    logic                          i_in_valid     = 1'b0;
    logic                          o_in_stall;
    logic signed [SAMPLE_BITS-1:0] i_real_part    = '0;
    logic signed [SAMPLE_BITS-1:0] i_imag_part    = '0;
    logic                          i_record_start = 1'b0;
    logic                          o_out_valid;
    logic                          i_out_stall    = 1'b0;
    logic signed [PHASE_BITS-1:0]  o_unwrapped_phase;
    logic signed [ANGLE_BITS-1:0]  o_wrapped_angle;
    logic                          o_saturated;

    int fail_count;
    int pending;
    int checked;
    int starts;
    int saturations;
    int idle_pct  = 0;
    int stall_pct = 0;
    int quiet     = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    complex_to_unwrapped_phase u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_real_part       (i_real_part),
        .i_imag_part       (i_imag_part),
        .i_record_start    (i_record_start),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_unwrapped_phase (o_unwrapped_phase),
        .o_wrapped_angle   (o_wrapped_angle),
        .o_saturated       (o_saturated)
    );

    complex_to_unwrapped_phase_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_real_part       (i_real_part),
        .i_imag_part       (i_imag_part),
        .i_record_start    (i_record_start),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_unwrapped_phase (o_unwrapped_phase),
        .i_wrapped_angle   (o_wrapped_angle),
        .i_saturated       (o_saturated),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_checked         (checked),
        .o_starts          (starts),
        .o_saturations     (saturations)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_out_stall <= 1'b0;
        else
            i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    function automatic real rand_unit();
        return real'($urandom_range(1000000)) / 1000000.0;
    endfunction

    function automatic int pick_radius();
        int sel;
        sel = $urandom_range(99);
        if (sel < 20)
            return $urandom_range(64, 1);
        else if (sel < 50)
            return $urandom_range(int'(S_MAX), 1);
        return $urandom_range(8000000, 4096);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] pick_part();
        case ($urandom_range(5))
            0:       return S_MIN;
            1:       return S_MAX;
            2:       return '0;
            3:       return '1;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] re,
                               input logic signed [SAMPLE_BITS-1:0] im,
                               input logic start);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_real_part    <= re;
        i_imag_part    <= im;
        i_record_start <= start;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    task automatic send_phasor(input real theta, input int radius, input logic start);
        int re;
        int im;
        re = $rtoi(radius * $cos(theta));
        im = $rtoi(radius * $sin(theta));
        send_sample(SAMPLE_BITS'(re), SAMPLE_BITS'(im), start);
    endtask

    // records: a start beat then a rotating phasor of random rate and size, some noise mixed in
    task automatic run_records(input int n_items);
        int  sent;
        int  len;
        real theta;
        real rate;
        sent = 0;
        while (sent < n_items) begin
            theta = rand_unit() * 2.0 * PI;
            rate  = (rand_unit() * 2.0 - 1.0) * PI;
            len   = $urandom_range(24, 2);
            send_phasor(theta, pick_radius(), 1'b1);
            sent++;
            for (int k = 1; k < len && sent < n_items; k++) begin
                if ($urandom_range(99) < 15) begin
                    send_sample(pick_part(), SAMPLE_BITS'($urandom), $urandom_range(9) == 0);
                end else begin
                    theta = theta + rate + (rand_unit() - 0.5) * 0.2;
                    send_phasor(theta, pick_radius(), 1'b0);
                end
                sent++;
            end
        end
    endtask

    // monotonic walk at close to the largest step the unwrap can follow
    task automatic run_ramp(input real dir);
        send_phasor(0.0, $urandom_range(8000000, 4096), 1'b1);
        for (int k = 1; k <= RAMP_ITEMS; k++)
            send_phasor(dir * k * RAMP_STEP + (rand_unit() - 0.5) * 0.04,
                        $urandom_range(8000000, 4096), 1'b0);
    endtask

    initial begin
        int idle_mix  [4] = '{0, 63, 0, 26};
        int stall_mix [4] = '{0, 0, 63, 26};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero sample, half-circle ties both ways, corners, tiny vectors, record starts
        send_sample('0, '0, 1'b0);
        send_sample(S_MIN, '0, 1'b0);
        send_sample(S_MAX, '0, 1'b0);
        send_sample('0, S_MAX, 1'b0);
        send_sample('0, S_MIN, 1'b0);
        send_sample(S_MIN, S_MIN, 1'b0);
        send_sample(S_MAX, S_MAX, 1'b0);
        send_sample(S_MIN, S_MAX, 1'b0);
        send_sample(S_MAX, S_MIN, 1'b0);
        send_sample(-24'sd1, '0, 1'b0);
        send_sample(-24'sd1, -24'sd1, 1'b0);
        send_sample(24'sd1, '0, 1'b0);
        send_sample('0, 24'sd1, 1'b0);
        send_sample(-24'sd1, 24'sd1, 1'b0);
        send_sample('0, -24'sd1, 1'b0);
        send_sample(-24'sd5, '0, 1'b1);
        send_sample(S_MIN, -24'sd1, 1'b1);
        send_sample(S_MAX, '0, 1'b1);
        send_sample(-24'sd1, '0, 1'b0);
        send_sample('0, '0, 1'b1);

        for (int p = 0; p < 4; p++) begin
            idle_pct  = idle_mix[p];
            stall_pct = stall_mix[p];
            run_records(PHASE_ITEMS);
        end

        idle_pct  = 0;
        stall_pct = 0;
        run_ramp(1.0);
        run_ramp(-1.0);

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Checked %0d result beats, %0d record starts, %0d clamped at a limit;",
                 checked, starts, saturations);
        $display("mixes of sender gaps and receiver stalls plus up and down phase ramps.");
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
